FILE: sv/prq_pkg.sv
// Package with types, constants and command codes for the priority ready-queue scheduler.
`default_nettype none
package prq_pkg;
	localparam int TASK_COUNT = 32;
	localparam int PRIORITY_BITS = 8;
	localparam int TW = $clog2(TASK_COUNT);
	localparam int PW = PRIORITY_BITS;

	typedef logic [TW-1:0] tid_t;
	typedef logic [PW-1:0] prio_t;

	typedef enum logic [2:0] {
		CMD_REGISTER = 3'd0,
		CMD_ACTIVATE = 3'd1,
		CMD_ISR_ACT  = 3'd2,
		CMD_BLOCK    = 3'd3,
		CMD_UNBLOCK  = 3'd4,
		CMD_TERM     = 3'd5,
		CMD_SETPRIO  = 3'd6,
		CMD_QUERY    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SUSPENDED = 2'd0,
		ST_READY     = 2'd1,
		ST_RUNNING   = 2'd2,
		ST_BLOCKED   = 2'd3
	} tstat_t;

	typedef struct packed {
		tstat_t status;
		prio_t  prio;
		logic [7:0] wait_on;
		logic   nvalid;
		tid_t   next;
	} entry_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CMD_RD, S_CMD_DEC, S_T_WR, S_NEXT,
		S_REM_RD, S_REM_CMP, S_REM_WR,
		S_INS_RD0, S_INS_LD, S_INS_RD, S_INS_CMP, S_INS_WR, S_INS_LINK,
		S_SCH_RD, S_SCH_HD, S_SCH_CMP, S_SCH_TAKE,
		S_FIN_RD, S_FIN_LD, S_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: sv/priority_ready_queue_scheduler.sv
// Top level of the priority ready-queue scheduler with its command sequencer.
`default_nettype none
// Hardware scheduler for 32 tasks kept in one task table memory (status, priority,
// wait resource and ready-list link per task). One command item is taken at a time.
// Each item passes a table read, a decode and a final read of the addressed task
// before its result is offered. The longest item, a set priority on a ready task
// that then preempts the running task, walks the ready list three times. After
// reset a clearing pass writes every table entry, one per cycle, and no item is
// accepted until it ends. os_started lies at address 0 of the APB port.
module priority_ready_queue_scheduler (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [2:0] command,
	input  wire logic [4:0] task_id,
	input  wire logic [7:0] priority_req,
	input  wire logic [7:0] resource,
	output logic out_valid,
	input  wire logic out_ready,
	output logic accepted,
	output logic running_valid,
	output logic [4:0] running_task,
	output logic switched,
	output logic [1:0] addressed_state,
	output logic [7:0] addressed_priority,
	output logic [7:0] waiting_resource,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import prq_pkg::*;

	state_t state_q, state_d;
	tid_t clr_cnt_q;
	logic os_q;

	cmd_t cmd_q;
	tid_t tid_q;
	prio_t preq_q;
	logic [7:0] res_q;

	logic head_v_q;
	tid_t head_q;
	logic cur_v_q;
	tid_t cur_q;
	logic was_v_q;
	tid_t was_t_q;
	logic acc_q;

	logic need_rem_q;
	logic need_ins_q;
	logic need_sch_q;
	tid_t op_t_q;
	tid_t wr_a_q;
	tid_t walk_q;
	tid_t prev_q;
	logic have_cur_q;
	logic have_prev_q;
	entry_t t_ent_q;
	entry_t op_ent_q;
	entry_t prev_ent_q;
	entry_t sch_ent_q;
	entry_t res_ent_q;

	logic dec_acc;
	logic dec_wr;
	logic dec_rem;
	logic dec_ins;
	logic dec_sch;
	logic dec_drop;
	entry_t dec_ent;

	logic we;
	tid_t waddr, raddr;
	entry_t wdata, rdata;

	prq_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign pready = 1'b1;
	assign prdata = {31'd0, os_q};
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			os_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			os_q <= pwdata[0];
		end
	end

	assign running_valid = cur_v_q;
	assign running_task = cur_v_q ? cur_q : '0;
	assign switched = (was_v_q != cur_v_q) || (cur_v_q && was_t_q != cur_q);
	assign accepted = acc_q;
	assign addressed_state = res_ent_q.status;
	assign addressed_priority = res_ent_q.prio;
	assign waiting_resource = res_ent_q.wait_on;

	// Command decode on the addressed entry, or the running entry for terminate.
	always_comb begin
		dec_acc = 1'b0;
		dec_wr = 1'b0;
		dec_rem = 1'b0;
		dec_ins = 1'b0;
		dec_sch = 1'b0;
		dec_drop = 1'b0;
		dec_ent = rdata;
		unique case (cmd_q)
			CMD_REGISTER: if (rdata.status == ST_SUSPENDED) begin
				dec_acc = 1'b1;
				dec_wr = 1'b1;
				dec_ent.prio = preq_q;
			end
			CMD_ACTIVATE, CMD_ISR_ACT: if (rdata.status == ST_SUSPENDED) begin
				dec_acc = 1'b1;
				dec_ins = 1'b1;
				dec_sch = (cmd_q == CMD_ACTIVATE) && os_q;
			end
			CMD_BLOCK: begin
				dec_acc = 1'b1;
				dec_wr = 1'b1;
				dec_ent.wait_on = res_q;
				dec_ent.status = ST_BLOCKED;
				dec_rem = (rdata.status == ST_READY);
				dec_drop = cur_v_q && (cur_q == tid_q);
				dec_sch = cur_v_q && (cur_q == tid_q);
			end
			CMD_UNBLOCK: if (rdata.status == ST_BLOCKED) begin
				dec_acc = 1'b1;
				dec_wr = 1'b1;
				dec_ent.wait_on = '0;
				dec_ins = 1'b1;
				dec_sch = 1'b1;
			end
			CMD_TERM: if (cur_v_q) begin
				dec_acc = 1'b1;
				dec_wr = 1'b1;
				dec_ent.status = ST_SUSPENDED;
				dec_drop = 1'b1;
				dec_sch = 1'b1;
			end
			CMD_SETPRIO: begin
				dec_acc = 1'b1;
				dec_wr = 1'b1;
				dec_ent.prio = preq_q;
				dec_rem = (rdata.status == ST_READY);
				dec_ins = (rdata.status == ST_READY);
				dec_sch = (rdata.status == ST_READY) || (rdata.status == ST_RUNNING);
			end
			CMD_QUERY: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_cnt_q == tid_t'(TASK_COUNT - 1)) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = S_CMD_RD;
			S_CMD_RD: state_d = S_CMD_DEC;
			S_CMD_DEC: state_d = dec_wr ? S_T_WR : S_NEXT;
			S_T_WR: state_d = S_NEXT;
			S_NEXT: begin
				priority if (need_rem_q) state_d = S_REM_RD;
				else if (need_ins_q) state_d = S_INS_RD0;
				else if (need_sch_q) state_d = S_SCH_RD;
				else state_d = S_FIN_RD;
			end
			S_REM_RD: state_d = have_cur_q ? S_REM_CMP : S_NEXT;
			S_REM_CMP: begin
				if (walk_q == op_t_q) state_d = have_prev_q ? S_REM_WR : S_NEXT;
				else state_d = S_REM_RD;
			end
			S_REM_WR: state_d = S_NEXT;
			S_INS_RD0: state_d = S_INS_LD;
			S_INS_LD: state_d = S_INS_RD;
			S_INS_RD: state_d = have_cur_q ? S_INS_CMP : S_INS_WR;
			S_INS_CMP: state_d = (op_ent_q.prio < rdata.prio) ? S_INS_WR : S_INS_RD;
			S_INS_WR: state_d = have_prev_q ? S_INS_LINK : S_NEXT;
			S_INS_LINK: state_d = S_NEXT;
			S_SCH_RD: state_d = head_v_q ? S_SCH_HD : S_NEXT;
			S_SCH_HD: state_d = cur_v_q ? S_SCH_CMP : S_SCH_TAKE;
			S_SCH_CMP: state_d = S_NEXT;
			S_SCH_TAKE: state_d = S_NEXT;
			S_FIN_RD: state_d = S_FIN_LD;
			S_FIN_LD: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = tid_q;
		wdata = '0;
		raddr = tid_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_cnt_q;
			end
			S_CMD_RD: raddr = (cmd_q == CMD_TERM) ? cur_q : tid_q;
			S_T_WR: begin
				we = 1'b1;
				waddr = wr_a_q;
				wdata = t_ent_q;
			end
			S_REM_RD: raddr = walk_q;
			S_REM_WR: begin
				we = 1'b1;
				waddr = prev_q;
				wdata = prev_ent_q;
			end
			S_INS_RD0: raddr = op_t_q;
			S_INS_RD: raddr = walk_q;
			S_INS_WR: begin
				we = 1'b1;
				waddr = op_t_q;
				wdata = op_ent_q;
				wdata.next = walk_q;
				wdata.nvalid = have_cur_q;
				wdata.status = ST_READY;
			end
			S_INS_LINK: begin
				we = 1'b1;
				waddr = prev_q;
				wdata = prev_ent_q;
				wdata.next = op_t_q;
				wdata.nvalid = 1'b1;
			end
			S_SCH_RD: raddr = head_q;
			S_SCH_HD: raddr = cur_q;
			S_SCH_TAKE: begin
				we = 1'b1;
				waddr = head_q;
				wdata = sch_ent_q;
				wdata.status = ST_RUNNING;
				wdata.nvalid = 1'b0;
			end
			S_FIN_RD: raddr = tid_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			cmd_q <= CMD_QUERY;
			tid_q <= '0;
			preq_q <= '0;
			res_q <= '0;
			head_v_q <= 1'b0;
			head_q <= '0;
			cur_v_q <= 1'b0;
			cur_q <= '0;
			was_v_q <= 1'b0;
			was_t_q <= '0;
			acc_q <= 1'b0;
			need_rem_q <= 1'b0;
			need_ins_q <= 1'b0;
			need_sch_q <= 1'b0;
			op_t_q <= '0;
			wr_a_q <= '0;
			walk_q <= '0;
			prev_q <= '0;
			have_cur_q <= 1'b0;
			have_prev_q <= 1'b0;
			t_ent_q <= '0;
			op_ent_q <= '0;
			prev_ent_q <= '0;
			sch_ent_q <= '0;
			res_ent_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLEAR: clr_cnt_q <= clr_cnt_q + 1'b1;
				S_IDLE: if (in_valid) begin
					cmd_q <= cmd_t'(command);
					tid_q <= task_id;
					preq_q <= priority_req;
					res_q <= resource;
					was_v_q <= cur_v_q;
					was_t_q <= cur_q;
				end
				S_CMD_DEC: begin
					acc_q <= dec_acc;
					t_ent_q <= dec_ent;
					wr_a_q <= (cmd_q == CMD_TERM) ? cur_q : tid_q;
					need_rem_q <= dec_rem;
					need_ins_q <= dec_ins;
					need_sch_q <= dec_sch;
					op_t_q <= tid_q;
					if (dec_drop) begin
						cur_v_q <= 1'b0;
						cur_q <= '0;
					end
				end
				S_NEXT: begin
					priority if (need_rem_q) begin
						need_rem_q <= 1'b0;
						walk_q <= head_q;
						have_cur_q <= head_v_q;
						have_prev_q <= 1'b0;
					end else if (need_ins_q) begin
						need_ins_q <= 1'b0;
					end else if (need_sch_q) begin
						need_sch_q <= 1'b0;
					end
				end
				S_REM_CMP: begin
					if (walk_q == op_t_q) begin
						if (have_prev_q) begin
							prev_ent_q.next <= rdata.next;
							prev_ent_q.nvalid <= rdata.nvalid;
						end else begin
							head_q <= rdata.next;
							head_v_q <= rdata.nvalid;
						end
					end else begin
						prev_q <= walk_q;
						prev_ent_q <= rdata;
						have_prev_q <= 1'b1;
						walk_q <= rdata.next;
						have_cur_q <= rdata.nvalid;
					end
				end
				S_INS_LD: begin
					op_ent_q <= rdata;
					walk_q <= head_q;
					have_cur_q <= head_v_q;
					have_prev_q <= 1'b0;
				end
				S_INS_CMP: if (!(op_ent_q.prio < rdata.prio)) begin
					prev_q <= walk_q;
					prev_ent_q <= rdata;
					have_prev_q <= 1'b1;
					walk_q <= rdata.next;
					have_cur_q <= rdata.nvalid;
				end
				S_INS_WR: if (!have_prev_q) begin
					head_q <= op_t_q;
					head_v_q <= 1'b1;
				end
				S_SCH_HD: sch_ent_q <= rdata;
				// A more urgent head sends the running task back to the list first.
				S_SCH_CMP: if (sch_ent_q.prio < rdata.prio) begin
					op_t_q <= cur_q;
					cur_v_q <= 1'b0;
					need_ins_q <= 1'b1;
					need_sch_q <= 1'b1;
				end
				S_SCH_TAKE: begin
					head_q <= sch_ent_q.next;
					head_v_q <= sch_ent_q.nvalid;
					cur_q <= head_q;
					cur_v_q <= 1'b1;
				end
				S_FIN_LD: res_ent_q <= rdata;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: sv/prq_ram.sv
// Task table with separate write and read ports and a registered read.
`default_nettype none
module prq_ram (
	input  wire logic clk,
	input  wire logic we,
	input  wire prq_pkg::tid_t waddr,
	input  wire prq_pkg::entry_t wdata,
	input  wire prq_pkg::tid_t raddr,
	output prq_pkg::entry_t rdata
);
	import prq_pkg::*;
	entry_t mem [TASK_COUNT];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
